/* rtl/salc_pkg.sv */
// package for the set associative lru tag cache
// shared constants, field widths and the back state type; no dependencies
package salc_pkg;
	localparam int SET_COUNT_DEF  = 64;
	localparam int WAYS_DEF       = 4;
	localparam int LINE_BYTES_DEF = 64;
	localparam int ADDR_BITS_DEF  = 64;
	localparam int TAG_W          = 52;
	localparam int CNT_W          = 64;
	localparam int PEN_W          = 16;
	localparam int WAY_W          = 2;
	localparam int CFG_IDX_W      = 1;
	localparam logic [PEN_W-1:0] PEN_RESET = 16'd100;
	localparam logic [CFG_IDX_W-1:0] REG_MISS_PENALTY  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CHARGE_ENABLE = 1'd1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_CLEAR
	} back_state_t;
endpackage

/* rtl/salc_front.sv */
// front part: accepts input words, cuts the address into set and tag, holds a two deep queue
// depends on salc_pkg
module salc_front import salc_pkg::*; #(
	parameter int SET_COUNT  = SET_COUNT_DEF,
	parameter int LINE_BYTES = LINE_BYTES_DEF,
	parameter int ADDR_BITS  = ADDR_BITS_DEF,
	localparam int SET_W     = (SET_COUNT > 1) ? $clog2(SET_COUNT + 1) - 1 : 0,
	localparam int SIDX_W    = (SET_W > 0) ? SET_W : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              in_mode,
	input  logic [63:0]       in_addr,
	output logic              q_valid,
	input  logic              q_pop,
	output logic              q_flush,
	output logic [SIDX_W-1:0] q_set,
	output logic [TAG_W-1:0]  q_tag
);
	localparam int OFF_W = $clog2(LINE_BYTES + 1) - 1;
	localparam int TAG_START = OFF_W + SET_W;

	logic [1:0]              cnt_q;
	logic                    rd_q, wr_q;
	logic [1:0]              flush_q;
	logic [1:0][SIDX_W-1:0]  set_q;
	logic [1:0][TAG_W-1:0]   tag_q;
	logic [63:0]             addr_m;
	logic [127:0]            addr_x;
	logic [SIDX_W-1:0]       set_c;
	logic [TAG_W-1:0]        tag_c;
	logic                    push;

	always_comb begin
		addr_m = in_addr;
		for (int i = 0; i < 64; i++) begin
			if (i >= ADDR_BITS) addr_m[i] = 1'b0;
		end
		addr_x = {64'd0, addr_m};
		if (SET_W > 0) set_c = SIDX_W'(addr_x >> OFF_W);
		else set_c = '0;
		if (TAG_START < 64) tag_c = TAG_W'(addr_x >> TAG_START);
		else tag_c = '0;
	end

	assign in_ready = (cnt_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_flush  = flush_q[rd_q];
	assign q_set    = set_q[rd_q];
	assign q_tag    = tag_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (q_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			flush_q[wr_q] <= in_mode;
			set_q[wr_q]   <= set_c;
			tag_q[wr_q]   <= tag_c;
		end
	end
endmodule

/* rtl/salc_back.sv */
// back part: reads a set, picks hit or lru way, writes back, clears on flush
// depends on salc_pkg
module salc_back import salc_pkg::*; #(
	parameter int SET_COUNT = SET_COUNT_DEF,
	parameter int WAYS      = WAYS_DEF,
	localparam int SET_W    = (SET_COUNT > 1) ? $clog2(SET_COUNT + 1) - 1 : 0,
	localparam int SIDX_W   = (SET_W > 0) ? SET_W : 1,
	localparam int RSET_W   = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	output logic              q_pop,
	input  logic              q_flush,
	input  logic [SIDX_W-1:0] q_set,
	input  logic [TAG_W-1:0]  q_tag,
	input  logic [PEN_W-1:0]  miss_penalty,
	input  logic              charge_enable,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              out_hit,
	output logic [WAY_W-1:0]  out_way,
	output logic [PEN_W-1:0]  out_pen,
	output logic [CNT_W-1:0]  out_acc,
	output logic [CNT_W-1:0]  out_miss
);
	localparam int WIDX_W = (WAYS > 1) ? $clog2(WAYS) : 1;

	typedef struct packed {
		logic [TAG_W-1:0] tag;
		logic [CNT_W-1:0] stamp;
	} line_t;

	line_t             mem_q [SET_COUNT][WAYS];
	line_t [WAYS-1:0]  rd_s1;
	logic [SET_COUNT-1:0][WAYS-1:0] valid_q;
	logic [WAYS-1:0]   vrow_s1;
	logic [WAYS-1:0][CNT_W-1:0] stamp_m;
	logic [RSET_W-1:0] set_s1;
	logic [TAG_W-1:0]  tag_s1;
	logic [CNT_W-1:0]  acc_q, miss_q;
	back_state_t       state_q, state_d;
	logic              found;
	logic [WIDX_W-1:0] hit_w, lru_w, pick;
	logic [RSET_W-1:0] rset;
	logic              wr_en, take;

	assign rset = (SET_W > 0 && 32'(q_set) < SET_COUNT) ? RSET_W'(q_set) : '0;

	always_comb begin
		found = 1'b0;
		hit_w = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (vrow_s1[w] && rd_s1[w].tag == tag_s1) begin
				found = 1'b1;
				hit_w = WIDX_W'(w);
			end
		end
		// invalid ways read with stamp treated as zero
		// a stale stamp of an invalid way would alter lru choice, so mask it
		for (int w = 0; w < WAYS; w++) begin
			stamp_m[w] = vrow_s1[w] ? rd_s1[w].stamp : '0;
		end
		lru_w = '0;
		for (int w = 1; w < WAYS; w++) begin
			if (stamp_m[w] < stamp_m[lru_w]) lru_w = WIDX_W'(w);
		end
		pick = found ? hit_w : lru_w;
	end

	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		take    = 1'b0;
		wr_en   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (q_valid && (!out_valid || out_ready)) begin
					q_pop = 1'b1;
					if (q_flush) begin
						state_d = ST_CLEAR;
					end else begin
						state_d = ST_LOOK;
					end
				end
			end
			ST_LOOK: begin
				take    = 1'b1;
				wr_en   = 1'b1;
				state_d = ST_IDLE;
			end
			ST_CLEAR: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			valid_q   <= '0;
			acc_q     <= '0;
			miss_q    <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (take || (q_pop && q_flush)) out_valid <= 1'b1;
			else if (out_valid && out_ready) out_valid <= 1'b0;
			if (q_pop && q_flush) valid_q <= '0;
			if (q_pop && !q_flush) acc_q <= acc_q + 1'b1;
			if (take) begin
				valid_q[set_s1][pick] <= 1'b1;
				if (!found) miss_q <= miss_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			set_s1  <= rset;
			tag_s1  <= q_tag;
			for (int w = 0; w < WAYS; w++) rd_s1[w] <= mem_q[rset][w];
			vrow_s1 <= valid_q[rset];
		end
		if (q_pop && q_flush) begin
			out_hit  <= 1'b0;
			out_way  <= '0;
			out_pen  <= '0;
			out_acc  <= acc_q;
			out_miss <= miss_q;
		end
		if (wr_en) begin
			mem_q[set_s1][pick] <= '{tag: tag_s1, stamp: acc_q};
			out_hit  <= found;
			out_way  <= WAY_W'(pick);
			out_pen  <= (!found && charge_enable) ? miss_penalty : '0;
			out_acc  <= acc_q;
			out_miss <= found ? miss_q : miss_q + 1'b1;
		end
	end
endmodule

/* rtl/set_assoc_lru_tag_cache.sv */
// lookups pass the queue, set read and output registers; flushes skip the set read registers
// the back pops only in ST_IDLE with room at the output; lookups read then write back the tags
// a two word queue between front and back and an output register decouple both sides
// reset clears valid bits, counters and config to 100 penalty with charging on
// top level, depends on salc_pkg, salc_front and salc_back
module set_assoc_lru_tag_cache import salc_pkg::*; #(
	parameter int SET_COUNT  = SET_COUNT_DEF,
	parameter int WAYS       = WAYS_DEF,
	parameter int LINE_BYTES = LINE_BYTES_DEF,
	parameter int ADDR_BITS  = ADDR_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [63:0]          s_axis_tdata,  // address
	input  logic                 s_axis_tuser,  // mode
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [151:0]         m_axis_tdata,  // hit, way, penalty_cycles, access_total, miss_total
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [PEN_W-1:0]     cfg_data
);
	localparam int SET_W  = (SET_COUNT > 1) ? $clog2(SET_COUNT + 1) - 1 : 0;
	localparam int SIDX_W = (SET_W > 0) ? SET_W : 1;

	logic [PEN_W-1:0]  pen_q;
	logic              chg_q;
	logic              q_valid, q_pop, q_flush;
	logic [SIDX_W-1:0] q_set;
	logic [TAG_W-1:0]  q_tag;
	logic              o_hit;
	logic [WAY_W-1:0]  o_way;
	logic [PEN_W-1:0]  o_pen;
	logic [CNT_W-1:0]  o_acc, o_miss;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pen_q <= PEN_RESET;
			chg_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MISS_PENALTY:  pen_q <= cfg_data;
				REG_CHARGE_ENABLE: chg_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	salc_front #(.SET_COUNT(SET_COUNT), .LINE_BYTES(LINE_BYTES), .ADDR_BITS(ADDR_BITS)) u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_mode(s_axis_tuser), .in_addr(s_axis_tdata),
		.q_valid, .q_pop, .q_flush, .q_set, .q_tag
	);

	salc_back #(.SET_COUNT(SET_COUNT), .WAYS(WAYS)) u_back (
		.clk, .arst_n,
		.q_valid, .q_pop, .q_flush, .q_set, .q_tag,
		.miss_penalty(pen_q), .charge_enable(chg_q),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_hit(o_hit), .out_way(o_way), .out_pen(o_pen), .out_acc(o_acc), .out_miss(o_miss)
	);

	assign m_axis_tdata = {5'd0, o_miss, o_acc, o_pen, o_way, o_hit};
endmodule

/* rtl/salc_checker.sv */
// port-level checker for the cache, bound to the top level
// depends on salc_pkg
module salc_checker import salc_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [151:0] m_axis_tdata
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output word changed while stalled");
	a_hit_nopen: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[18:3] == '0)
		else $error("penalty on a hit");
	a_miss_le: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[146:83] <= m_axis_tdata[82:19]
		|| m_axis_tdata[82:19] < 64'd2)
		else $error("hit with more misses than accesses");
endmodule

bind set_assoc_lru_tag_cache salc_checker u_chk (
	.clk, .arst_n, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);

/* test/set_assoc_lru_tag_cache_check.sv */
// checker for the set associative lru tag cache: watches both streams,
// predicts each result word with its own tag, valid and stamp arrays and compares
// depends on salc_pkg
`timescale 1ns / 1ps
module set_assoc_lru_tag_cache_check import salc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [63:0]  s_axis_tdata,
	input  logic         s_axis_tuser,
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [151:0] m_axis_tdata,
	input  logic         cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [PEN_W-1:0]     cfg_data,
	output int           fail_count,
	output int           pending
);
	localparam int LINES = SET_COUNT_DEF * WAYS_DEF;

	typedef struct packed {
		logic [CNT_W-1:0] miss_total;
		logic [CNT_W-1:0] access_total;
		logic [PEN_W-1:0] penalty_cycles;
		logic [WAY_W-1:0] way;
		logic             hit;
	} lookup_word_t;

	logic [TAG_W-1:0] tags [LINES];
	logic             valid [LINES];
	logic [CNT_W-1:0] stamp [LINES];
	logic [CNT_W-1:0] accesses, misses;
	logic [PEN_W-1:0] penalty;
	logic             charge;
	lookup_word_t     expected_words[$];

	function automatic lookup_word_t predict_lookup(logic mode, logic [63:0] addr);
		lookup_word_t r;
		logic [5:0] set_idx;
		logic [TAG_W-1:0] tag;
		int base, pick;
		logic found;
		r = '0;
		if (mode) begin
			for (int i = 0; i < LINES; i++) begin
				tags[i] = '0;
				valid[i] = 1'b0;
				stamp[i] = '0;
			end
		end else begin
			set_idx = addr[11:6];
			tag = addr[63:12];
			base = set_idx * WAYS_DEF;
			accesses = accesses + 1;
			found = 1'b0;
			pick = 0;
			for (int w = 0; w < WAYS_DEF; w++)
				if (!found && valid[base + w] && tags[base + w] == tag) begin
					found = 1'b1;
					pick = w;
				end
			if (!found) begin
				pick = 0;
				for (int w = 1; w < WAYS_DEF; w++)
					if (stamp[base + w] < stamp[base + pick])
						pick = w;
				tags[base + pick] = tag;
				valid[base + pick] = 1'b1;
				misses = misses + 1;
				if (charge)
					r.penalty_cycles = penalty;
			end
			stamp[base + pick] = accesses;
			r.hit = found;
			r.way = pick[WAY_W-1:0];
		end
		r.access_total = accesses;
		r.miss_total = misses;
		return r;
	endfunction

	assign pending = expected_words.size();

	always @(posedge clk or negedge arst_n) begin
		lookup_word_t got, want;
		if (!arst_n) begin
			for (int i = 0; i < LINES; i++) begin
				tags[i] = '0;
				valid[i] = 1'b0;
				stamp[i] = '0;
			end
			accesses = '0;
			misses = '0;
			penalty = PEN_RESET;
			charge = 1'b1;
			fail_count = 0;
			expected_words.delete();
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_MISS_PENALTY)
					penalty = cfg_data;
				else if (cfg_index == REG_CHARGE_ENABLE)
					charge = cfg_data[0];
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata[146:0];
				if (expected_words.size() == 0) begin
					$error("unexpected result word %h", m_axis_tdata);
					fail_count++;
				end else begin
					want = expected_words.pop_front();
					if (got.hit !== want.hit) begin
						$error("hit: expected %0d got %0d", want.hit, got.hit);
						fail_count++;
					end
					if (got.way !== want.way) begin
						$error("way: expected %0d got %0d", want.way, got.way);
						fail_count++;
					end
					if (got.penalty_cycles !== want.penalty_cycles) begin
						$error("penalty_cycles: expected %0d got %0d",
							want.penalty_cycles, got.penalty_cycles);
						fail_count++;
					end
					if (got.access_total !== want.access_total) begin
						$error("access_total: expected %0d got %0d",
							want.access_total, got.access_total);
						fail_count++;
					end
					if (got.miss_total !== want.miss_total) begin
						$error("miss_total: expected %0d got %0d",
							want.miss_total, got.miss_total);
						fail_count++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				expected_words.push_back(predict_lookup(s_axis_tuser, s_axis_tdata));
		end
	end
endmodule

/* test/set_assoc_lru_tag_cache_test.sv */
// testbench top for the set associative lru tag cache: drives lookups, flushes
// and register writes under several idling phases; the checker does the comparing
// depends on salc_pkg, set_assoc_lru_tag_cache and set_assoc_lru_tag_cache_check
`timescale 1ns / 1ps
module set_assoc_lru_tag_cache_test import salc_pkg::*;;
	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [63:0]  s_axis_tdata = '0;  // address
	logic         s_axis_tuser = 1'b0;  // mode
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [151:0] m_axis_tdata;  // hit, way, penalty_cycles, access_total, miss_total
	logic         cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [PEN_W-1:0]     cfg_data = '0;
	int fail_count, pending;
	int send_idle_pct = 0, recv_stall_pct = 0;
	logic [63:0] hot_addr [16];

	always #5 clk = ~clk;

	set_assoc_lru_tag_cache i_dut (.*);
	set_assoc_lru_tag_cache_check i_check (.*);

	always @(posedge clk)
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

	task automatic send_word(logic mode, logic [63:0] addr);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= mode;
		s_axis_tdata <= addr;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic drain;
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [PEN_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	// mostly reuse of a small pool of lines sharing a few sets, some fully random, some random in the low 18 bits
	function automatic logic [63:0] pick_address();
		logic [63:0] a;
		case ($urandom_range(9))
			0: a = {$urandom, $urandom};
			1: a = {$urandom, $urandom} & 64'h0000_0000_0003_ffff;
			default: a = hot_addr[$urandom_range(15)] | $urandom_range(63);
		endcase
		return a;
	endfunction

	initial begin
		logic [63:0] a;
		for (int i = 0; i < 16; i++)
			hot_addr[i] = ({$urandom, $urandom} & ~64'hfff) | ((i % 3) << 6);
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_word(1'b0, 64'h0);
		send_word(1'b0, 64'h0);
		send_word(1'b0, 64'hffff_ffff_ffff_ffff);
		send_word(1'b0, 64'hffff_ffff_ffff_ffff);
		send_word(1'b1, 64'hffff_ffff_ffff_ffff);
		send_word(1'b0, 64'h0);
		// five tags in one set force an lru eviction
		for (int i = 0; i < 5; i++)
			send_word(1'b0, 64'h40 | (64'(i) << 12));
		send_word(1'b0, 64'h40 | (64'd1 << 12));
		send_word(1'b0, 64'h40);
		send_word(1'b0, 64'hfff);
		send_word(1'b0, 64'h5555_5555_5555_5555);
		send_word(1'b0, 64'haaaa_aaaa_aaaa_aaaa);
		drain();
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin write_reg(REG_MISS_PENALTY, 16'hffff); write_reg(REG_CHARGE_ENABLE, 1'b1); end
				1: begin write_reg(REG_MISS_PENALTY, 16'h0000); end
				2: begin write_reg(REG_CHARGE_ENABLE, 1'b0); write_reg(REG_MISS_PENALTY, 16'h1234); end
				default: begin write_reg(REG_CHARGE_ENABLE, 1'b1);
					write_reg(REG_MISS_PENALTY, 16'($urandom)); end
			endcase
			cfg_we <= 1'b0;
			send_idle_pct = (phase == 1 || phase == 3) ? 64 : 0;
			recv_stall_pct = (phase == 2 || phase == 3) ? 64 : 0;
			if (phase == 3) begin
				send_idle_pct = 21;
				recv_stall_pct = 21;
			end
			for (int n = 0; n < 125; n++) begin
				a = pick_address();
				send_word($urandom_range(40) == 0, a);
			end
			drain();
		end
		if (fail_count == 0)
			$display("set_assoc_lru_tag_cache regression: pass");
		else
			$display("set_assoc_lru_tag_cache regression: fail");
		$finish;
	end

	initial begin
		#2ms;
		$display("set_assoc_lru_tag_cache regression: fail");
		$finish;
	end
endmodule

/* filelist.f */
rtl/salc_pkg.sv
rtl/salc_front.sv
rtl/salc_back.sv
rtl/set_assoc_lru_tag_cache.sv
rtl/salc_checker.sv
test/set_assoc_lru_tag_cache_check.sv
test/set_assoc_lru_tag_cache_test.sv
